>>> sv/rws_pkg.sv
// rolling window statistics: shared types, widths and codes
// used by the scan, the top level and the testbench; depends on nothing
`timescale 1ns / 1ps

package rws_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int WINDOW_MAX  = 64;
  localparam int PTR_W       = $clog2(WINDOW_MAX);
  localparam int CNT_W       = 7;
  localparam int SUM_W       = SAMPLE_BITS + PTR_W + 1;
  localparam int MAG_W       = SUM_W - 1;
  localparam int SQ_W        = 2 * SAMPLE_BITS + PTR_W;
  localparam int NUM_W       = 2 * MAG_W;
  localparam int NN_W        = 2 * PTR_W + 1;
  localparam int ROOT_W      = NUM_W / 2;
  localparam int STD_W       = SAMPLE_BITS - 1;
  localparam logic [STD_W-1:0] STD_MAX = {STD_W{1'b1}};

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES   = 1'b1;

  localparam logic [CNT_W-1:0] WINDOW_LENGTH_RESET = 7'd64;
  localparam logic [CNT_W-1:0] MIN_SAMPLES_RESET   = 7'd1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          series_start;
  } in_word_t;

  typedef struct packed {
    logic                          ready_res;
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic        [STD_W-1:0]       std_value;
    logic        [CNT_W-1:0]       used_count;
  } out_word_t;

  typedef struct packed {
    logic                          wr_en;
    logic [PTR_W-1:0]              wr_addr;
    logic signed [SAMPLE_BITS-1:0] wr_data;
    logic                          start;
    logic [PTR_W-1:0]              start_ptr;
    logic [CNT_W-1:0]              used;
  } scan_ctl_t;

  typedef struct packed {
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic signed [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]               sq;
  } scan_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIVGO,
    ST_DIV,
    ST_SQGO,
    ST_SQRT,
    ST_DONE
  } state_t;

endpackage

>>> sv/rws_scan.sv
// sample ring and window scan: max, min, sum and sum of squares
// one entry per cycle; uses rws_pkg
`timescale 1ns / 1ps

module rws_scan (
  input  logic                clk,
  input  logic                rst,
  input  rws_pkg::scan_ctl_t  ctl,
  output rws_pkg::scan_res_t  res
);

  localparam int SB = rws_pkg::SAMPLE_BITS;

  logic signed [SB-1:0] ring [rws_pkg::WINDOW_MAX];

  logic [rws_pkg::PTR_W-1:0] rd_ptr;
  logic [rws_pkg::PTR_W-1:0] rd_addr;
  logic [rws_pkg::CNT_W-1:0] remain;
  logic                      issuing;
  logic                      rd_valid;
  logic                      prod_valid;
  logic                      busy;
  logic signed [SB-1:0]      rd_data;
  logic [SB-1:0]             rd_mag;
  logic [2*SB-1:0]           prod;
  logic signed [SB-1:0]      mx;
  logic signed [SB-1:0]      mn;
  logic signed [rws_pkg::SUM_W-1:0] sum;
  logic [rws_pkg::SQ_W-1:0]  sq;

  assign rd_addr = (rd_ptr == '0) ? rws_pkg::PTR_W'(rws_pkg::WINDOW_MAX - 1) : rd_ptr - 1'b1;
  assign rd_mag  = rd_data[SB-1] ? SB'(-rd_data) : SB'(rd_data);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ring[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing    <= 1'b0;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      busy       <= 1'b0;
    end else begin
      rd_valid   <= issuing;
      prod_valid <= rd_valid;
      if (ctl.start) begin
        issuing <= (ctl.used != '0);
        busy    <= 1'b1;
      end else begin
        if (issuing && remain == rws_pkg::CNT_W'(1)) begin
          issuing <= 1'b0;
        end
        if (res.done) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rd_ptr <= ctl.start_ptr;
      remain <= ctl.used;
      mx     <= {1'b1, {(SB-1){1'b0}}};
      mn     <= {1'b0, {(SB-1){1'b1}}};
      sum    <= '0;
      sq     <= '0;
    end else begin
      if (issuing) begin
        rd_ptr <= rd_addr;
        remain <= remain - 1'b1;
      end
      if (rd_valid) begin
        if (rd_data > mx) mx <= rd_data;
        if (rd_data < mn) mn <= rd_data;
        sum  <= sum + {{(rws_pkg::SUM_W-SB){rd_data[SB-1]}}, rd_data};
        prod <= rd_mag * rd_mag;
      end
      if (prod_valid) begin
        sq <= sq + rws_pkg::SQ_W'(prod);
      end
    end
  end

  assign res.done      = busy && !ctl.start && !issuing && !rd_valid && !prod_valid;
  assign res.max_value = mx;
  assign res.min_value = mn;
  assign res.sum       = sum;
  assign res.sq        = sq;

endmodule

>>> sv/rws_div.sv
// restoring divider, one quotient bit per cycle
// standalone; widths set by parameters
`timescale 1ns / 1ps

module rws_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NUM_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
    end
  end

endmodule

>>> sv/rws_sqrt.sv
// floor square root, two radicand bits and one root bit per cycle
// standalone; widths set by parameters
`timescale 1ns / 1ps

module rws_sqrt #(
  parameter int RAD_W = 60
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAD_W-1:0]     rad,
  output logic                 busy,
  output logic [RAD_W/2-1:0]   root
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CW     = $clog2(ROOT_W + 1);

  logic [CW-1:0]      cnt;
  logic [RAD_W-1:0]   rad_sh;
  logic [REM_W-1:0]   rem;
  logic [REM_W+1:0]   shifted;
  logic [REM_W+1:0]   trial;
  logic               ge;

  assign shifted = {rem, rad_sh[RAD_W-1:RAD_W-2]};
  assign trial   = (REM_W+2)'({root, 2'b01});
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(ROOT_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[RAD_W-3:0], 2'b00};
      rem    <= ge ? REM_W'(shifted - trial) : REM_W'(shifted);
      root   <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

>>> sv/rolling_window_statistics_core.sv
// rolling window statistics top level: config, sequencer, output register
// a ready word passes the scan, the n*sq multiply, the mean and variance divides,
// the square root and the output register; a non-ready word goes straight to the
// output register; one word in flight at a time; throughput set by the whole sequence
// reset (synchronous): pointer, count and sequencer cleared, window 64, min samples 1
// the sample ring needs no clearing; only entries of the current series are read
`timescale 1ns / 1ps

module rolling_window_statistics_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rws_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rws_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rws_pkg::CNT_W-1:0]           cfg_data
);

  localparam int SB    = rws_pkg::SAMPLE_BITS;
  localparam int CNT_W = rws_pkg::CNT_W;
  localparam int PTR_W = rws_pkg::PTR_W;
  localparam int NUM_W = rws_pkg::NUM_W;
  localparam int MAG_W = rws_pkg::MAG_W;
  localparam int NN_W  = rws_pkg::NN_W;
  localparam int MCW   = $clog2(CNT_W + 1);
  localparam logic [CNT_W-1:0] WMAX = CNT_W'(rws_pkg::WINDOW_MAX);

  rws_pkg::state_t state, state_next;

  logic [CNT_W-1:0] window_length;
  logic [CNT_W-1:0] min_samples;
  logic [PTR_W-1:0] wp;
  logic [CNT_W-1:0] sample_count;

  logic             accept;
  logic [PTR_W-1:0] base_wp;
  logic [PTR_W-1:0] wp_new;
  logic [CNT_W-1:0] base_cnt;
  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0] wl;
  logic [CNT_W-1:0] need;
  logic             is_ready;
  logic [CNT_W-1:0] used;

  rws_pkg::scan_ctl_t scan_ctl;
  rws_pkg::scan_res_t scan_res;

  logic                    res_ok;
  logic [CNT_W-1:0]        n;
  logic                    neg;
  logic [MAG_W-1:0]        mag;
  logic signed [SB-1:0]    mx;
  logic signed [SB-1:0]    mn;
  logic [NUM_W-1:0]        sq_sh;
  logic [CNT_W-1:0]        n_sh;
  logic [NUM_W-1:0]        nsq;
  logic [NUM_W-1:0]        magsq;
  logic [NN_W-1:0]         nn;
  logic [MCW-1:0]          mul_cnt;
  logic [MAG_W-1:0]        mag_c;

  logic                    div_start;
  logic                    sq_start;
  logic                    mean_busy;
  logic                    var_busy;
  logic                    root_busy;
  logic [MAG_W-1:0]        mean_q;
  logic [NUM_W-1:0]        var_q;
  logic [NUM_W/2-1:0]      root;
  logic                    load_out;
  rws_pkg::out_word_t      res;

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= rws_pkg::WINDOW_LENGTH_RESET;
      min_samples   <= rws_pkg::MIN_SAMPLES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rws_pkg::CFG_WINDOW_LENGTH: window_length <= cfg_data;
        rws_pkg::CFG_MIN_SAMPLES:   min_samples   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && in_ready;
  assign base_wp  = in_data.series_start ? '0 : wp;
  assign base_cnt = in_data.series_start ? '0 : sample_count;
  assign wp_new   = (base_wp == PTR_W'(rws_pkg::WINDOW_MAX - 1)) ? '0 : base_wp + 1'b1;
  assign cnt_new  = (base_cnt < WMAX) ? base_cnt + 1'b1 : base_cnt;
  assign wl       = (window_length > WMAX) ? WMAX : window_length;
  assign need     = (min_samples == '0) ? CNT_W'(1) : min_samples;
  assign is_ready = (wl != '0) && (cnt_new >= need);
  assign used     = (cnt_new < wl) ? cnt_new : wl;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp           <= '0;
      sample_count <= '0;
    end else if (accept) begin
      wp           <= wp_new;
      sample_count <= cnt_new;
    end
  end

  always_comb begin
    scan_ctl.wr_en     = accept;
    scan_ctl.wr_addr   = base_wp;
    scan_ctl.wr_data   = in_data.sample;
    scan_ctl.start     = accept && is_ready;
    scan_ctl.start_ptr = wp_new;
    scan_ctl.used      = used;
  end

  rws_scan u_scan (
    .clk (clk),
    .rst (rst),
    .ctl (scan_ctl),
    .res (scan_res)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      rws_pkg::ST_IDLE:  if (in_valid) state_next = is_ready ? rws_pkg::ST_SCAN : rws_pkg::ST_DONE;
      rws_pkg::ST_SCAN:  if (scan_res.done) state_next = rws_pkg::ST_MUL;
      rws_pkg::ST_MUL:   if (mul_cnt == MCW'(CNT_W)) state_next = rws_pkg::ST_DIVGO;
      rws_pkg::ST_DIVGO: state_next = rws_pkg::ST_DIV;
      rws_pkg::ST_DIV:   if (!mean_busy && !var_busy) state_next = rws_pkg::ST_SQGO;
      rws_pkg::ST_SQGO:  state_next = rws_pkg::ST_SQRT;
      rws_pkg::ST_SQRT:  if (!root_busy) state_next = rws_pkg::ST_DONE;
      rws_pkg::ST_DONE:  if (!out_valid || out_ready) state_next = rws_pkg::ST_IDLE;
      default:           state_next = rws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == rws_pkg::ST_IDLE);
    div_start = (state == rws_pkg::ST_DIVGO);
    sq_start  = (state == rws_pkg::ST_SQGO);
    load_out  = (state == rws_pkg::ST_DONE) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rws_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign mag_c = scan_res.sum[rws_pkg::SUM_W-1] ? MAG_W'(-scan_res.sum) : MAG_W'(scan_res.sum);

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ok <= is_ready;
      n      <= used;
    end
    if (state == rws_pkg::ST_SCAN && scan_res.done) begin
      neg     <= scan_res.sum[rws_pkg::SUM_W-1];
      mag     <= mag_c;
      mx      <= scan_res.max_value;
      mn      <= scan_res.min_value;
      sq_sh   <= NUM_W'(scan_res.sq);
      n_sh    <= n;
      nsq     <= '0;
      mul_cnt <= '0;
    end
    // n * sum of squares by shift and add, one bit of n a cycle
    if (state == rws_pkg::ST_MUL) begin
      if (n_sh[0]) nsq <= nsq + sq_sh;
      sq_sh   <= {sq_sh[NUM_W-2:0], 1'b0};
      n_sh    <= n_sh >> 1;
      mul_cnt <= mul_cnt + 1'b1;
      magsq   <= mag * mag;
      nn      <= NN_W'(n) * NN_W'(n);
    end
  end

  rws_div #(.NUM_W(MAG_W), .DEN_W(CNT_W)) u_mean_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mag),
    .den   (n),
    .busy  (mean_busy),
    .quo   (mean_q)
  );

  // n*S2 - S1^2 is never negative
  rws_div #(.NUM_W(NUM_W), .DEN_W(rws_pkg::NN_W)) u_var_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (nsq - magsq),
    .den   (nn),
    .busy  (var_busy),
    .quo   (var_q)
  );

  rws_sqrt #(.RAD_W(NUM_W)) u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (var_q),
    .busy  (root_busy),
    .root  (root)
  );

  always_comb begin
    res = '0;
    if (res_ok) begin
      res.ready_res  = 1'b1;
      res.mean_value = neg ? SB'(-mean_q) : SB'(mean_q);
      res.max_value  = mx;
      res.min_value  = mn;
      res.std_value  = (root > (NUM_W/2)'(rws_pkg::STD_MAX)) ? rws_pkg::STD_MAX
                                                             : rws_pkg::STD_W'(root);
      res.used_count = n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    scan_res.done |-> state == rws_pkg::ST_SCAN)
    else $error("scan finished outside scan state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != rws_pkg::ST_IDLE)
    else $error("accepted word did not start work");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ready_res |-> out_data.mean_value == '0 &&
      out_data.max_value == '0 && out_data.min_value == '0 &&
      out_data.std_value == '0 && out_data.used_count == '0)
    else $error("non-ready word carries data");

  a_ready_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ready_res |-> out_data.max_value >= out_data.min_value &&
      out_data.used_count != '0 && out_data.used_count <= WMAX)
    else $error("ready word has bad range or count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= WMAX)
    else $error("sample count above window depth");

endmodule

>>> sim/tb_rolling_window_statistics_core.sv
// testbench for rolling_window_statistics_core: random and directed samples
// checked against an in-bench window predictor; depends on rws_pkg and the core
`timescale 1ns / 1ps

module tb_rolling_window_statistics_core;

  localparam int SB     = rws_pkg::SAMPLE_BITS;
  localparam int WMAX   = rws_pkg::WINDOW_MAX;
  localparam int CNT_W  = rws_pkg::CNT_W;
  localparam int IDX_W  = rws_pkg::CFG_IDX_W;
  localparam int STD_W  = rws_pkg::STD_W;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rws_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rws_pkg::out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;

  rolling_window_statistics_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [SB-1:0] ring [WMAX];
  int unsigned ring_wp = 0;
  int unsigned series_len = 0;
  logic [CNT_W-1:0] win_len = rws_pkg::WINDOW_LENGTH_RESET;
  logic [CNT_W-1:0] need_len = rws_pkg::MIN_SAMPLES_RESET;

  rws_pkg::in_word_t pending_words[$];
  rws_pkg::out_word_t stats_due[$];
  int errors = 0;
  int words_seen = 0;
  bit idle_on = 1'b1;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic rws_pkg::out_word_t window_stats(rws_pkg::in_word_t w);
    rws_pkg::out_word_t o;
    int unsigned wl, need, used, pos;
    longint s1, v;
    longint unsigned s2, mag, av, num, sd, n;
    logic signed [SB-1:0] hi, lo;
    o = '0;
    if (w.series_start) begin
      ring_wp = 0;
      series_len = 0;
    end
    ring[ring_wp] = w.sample;
    ring_wp = (ring_wp + 1) % WMAX;
    if (series_len < WMAX) series_len++;
    wl = (win_len > WMAX) ? WMAX : win_len;
    need = (need_len == 0) ? 1 : need_len;
    if (wl == 0 || series_len < need) return o;
    used = (series_len < wl) ? series_len : wl;
    hi = {1'b1, {(SB-1){1'b0}}};
    lo = {1'b0, {(SB-1){1'b1}}};
    s1 = 0;
    s2 = 0;
    pos = ring_wp;
    for (int i = 0; i < used; i++) begin
      pos = (pos == 0) ? WMAX - 1 : pos - 1;
      v = ring[pos];
      if (ring[pos] > hi) hi = ring[pos];
      if (ring[pos] < lo) lo = ring[pos];
      s1 += v;
      av = (v < 0) ? -v : v;
      s2 += av * av;
    end
    n = used;
    mag = (s1 < 0) ? -s1 : s1;
    num = n * s2 - mag * mag;
    sd = floor_root(num / (n * n));
    if (sd > rws_pkg::STD_MAX) sd = rws_pkg::STD_MAX;
    o.ready_res = 1'b1;
    o.mean_value = (s1 < 0) ? SB'(-(mag / n)) : SB'(mag / n);
    o.max_value = hi;
    o.min_value = lo;
    o.std_value = sd[STD_W-1:0];
    o.used_count = n[CNT_W-1:0];
    return o;
  endfunction

  // sender: bursts with gaps, predicts each accepted word
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    bit take;
    take = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) stats_due.push_back(window_stats(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
          take = 1'b1;
          in_data <= pending_words.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= idle_on ? $urandom_range(0, 6) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        in_valid <= take;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (words_seen == 300 && !hold_done) begin
      hold_cnt <= 900;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 23;
    if (rst) out_ready <= 1'b0;
    else out_ready <= (hold_cnt == 0) && (!idle_on || stall_phase < 15 || $urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    rws_pkg::out_word_t e;
    if (!rst && out_valid && out_ready) begin
      words_seen <= words_seen + 1;
      if (stats_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", out_data);
      end else begin
        e = stats_due.pop_front();
        if (e !== out_data) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rws_pkg::CFG_WINDOW_LENGTH) win_len = val;
    else need_len = val;
  endtask

  task automatic push_word(logic signed [SB-1:0] s, logic st);
    rws_pkg::in_word_t w;
    w.sample = s;
    w.series_start = st;
    pending_words.push_back(w);
  endtask

  function automatic logic signed [SB-1:0] any_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      1, 2, 3: return SB'($signed($urandom_range(0, 2000)) - 1000);
      default: return SB'($urandom);
    endcase
  endfunction

  // quiet point: all words sent and all results back, then the pipeline settles
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_words.size() > 0 || in_valid || stats_due.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  int wl_set[10] = '{64, 1, 2, 0, 64, 127, 7, 33, 5, 64};
  int ms_set[10] = '{1, 0, 2, 1, 64, 100, 3, 127, 5, 1};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, equal values, restarts
    push_word(24'sh7FFFFF, 1'b1);
    push_word(24'sh7FFFFF, 1'b0);
    push_word(24'sh800000, 1'b0);
    push_word(24'sh800000, 1'b0);
    push_word(-24'sd1, 1'b0);
    push_word(24'sd0, 1'b0);
    push_word(24'sd1, 1'b0);
    push_word(-24'sd3, 1'b1);
    push_word(24'sd2, 1'b0);
    push_word(-24'sd3, 1'b1);
    push_word(24'sh555555, 1'b0);
    push_word(24'shAAAAAA, 1'b0);
    drain();
    write_reg(rws_pkg::CFG_WINDOW_LENGTH, 7'd2);
    write_reg(rws_pkg::CFG_MIN_SAMPLES, 7'd0);
    for (int i = 0; i < 8; i++) push_word(i[0] ? 24'sh800000 : 24'sh7FFFFF, i == 0);
    drain();
    for (int p = 0; p < 10; p++) begin
      if (p >= 8) begin
        wl_set[p] = $urandom_range(0, 127);
        ms_set[p] = $urandom_range(0, 70);
      end
      write_reg(rws_pkg::CFG_WINDOW_LENGTH, CNT_W'(wl_set[p]));
      write_reg(rws_pkg::CFG_MIN_SAMPLES, CNT_W'(ms_set[p]));
      idle_on = (p % 3) != 2;
      for (int i = 0; i < 153; i++) push_word(any_sample(), i == 0 || $urandom_range(0, 59) == 0);
      drain();
    end
    if (stats_due.size() != 0) errors++;
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
